@@ hw/rtl/rec_pkg.sv @@
package rec_pkg;

    localparam int MIN_EDGE     = 8;
    localparam int FRONT_STAGES = 3;
    localparam int ITER_STAGES  = 3;

    typedef struct packed {
        logic pre_ok;
        logic corner_on;
    } rec_flags_t;

endpackage

@@ hw/rtl/rec_front.sv @@
module rec_front #(
    parameter int FRAC_BITS  = 8,
    parameter int EDGE_BITS  = 8,
    parameter int COORD_BITS = 11
) (
    input  logic                               aclk,
    input  logic [rec_pkg::FRONT_STAGES-1:0]   stage_en,
    input  logic signed [COORD_BITS-1:0]       pos_x,
    input  logic signed [COORD_BITS-1:0]       pos_y,
    input  logic [EDGE_BITS-1:0]               eye_w,
    input  logic [EDGE_BITS-1:0]               eye_height,
    input  logic                               left_side,
    input  logic [FRAC_BITS:0]                 corner_fraction,
    input  logic [FRAC_BITS:0]                 top_outer_lid,
    input  logic [FRAC_BITS:0]                 top_inner_lid,
    input  logic [FRAC_BITS:0]                 bottom_outer_lid,
    input  logic [FRAC_BITS:0]                 bottom_inner_lid,
    input  logic [EDGE_BITS-1:0]               column,
    output logic [2*EDGE_BITS:0]               div_top,
    output logic [2*EDGE_BITS:0]               div_bot,
    output logic [EDGE_BITS-1:0]               divisor,
    output logic [2*EDGE_BITS-3:0]             root_arg,
    output logic [EDGE_BITS-2:0]               radius,
    output logic [EDGE_BITS-1:0]               height,
    output logic signed [COORD_BITS:0]         span_x,
    output logic signed [COORD_BITS:0]         y_base,
    output rec_pkg::rec_flags_t                flags
);
    import rec_pkg::*;

    localparam int PW = FRAC_BITS + EDGE_BITS + 1;
    localparam int RB = EDGE_BITS - 1;
    localparam int SW = 2 * RB;
    localparam int DW = 2 * EDGE_BITS + 1;
    localparam int MW = FRAC_BITS + 2 * EDGE_BITS + 1;

    // stage A
    logic                        pre_ok_a_next, pre_ok_a_reg;
    logic [EDGE_BITS-1:0]        wm1_a_next, wm1_a_reg;
    logic [EDGE_BITS-1:0]        edist_a_next, edist_a_reg;
    logic [RB-1:0]               half_w_a_reg, half_h_a_reg;
    logic [EDGE_BITS-1:0]        h_a_reg;
    logic [PW-1:0]               p_tl_a_next, p_tr_a_next, p_bl_a_next, p_br_a_next;
    logic [PW-1:0]               p_tl_a_reg, p_tr_a_reg, p_bl_a_reg, p_br_a_reg;
    logic [PW-1:0]               rprod_a_next, rprod_a_reg;
    logic signed [COORD_BITS:0]  x_a_next, x_a_reg;
    logic signed [COORD_BITS:0]  y0_a_next, y0_a_reg;
    logic [EDGE_BITS-1:0]        rdist;
    logic [EDGE_BITS-1:0]        short_side;
    logic [FRAC_BITS:0]          tl, tr, bl, br;

    // stage B
    logic [PW-1:0]               sum_t_b_next, sum_b_b_next, sum_t_b_reg, sum_b_b_reg;
    logic [RB-1:0]               radius_b_next, radius_b_reg;
    logic                        pre_ok_b_reg;
    logic [EDGE_BITS-1:0]        wm1_b_reg, edist_b_reg, h_b_reg;
    logic signed [COORD_BITS:0]  x_b_reg, y0_b_reg;
    logic [EDGE_BITS:0]          r0;
    logic [RB-1:0]               r1, r2;

    // stage C
    logic [MW-1:0]               prod_t, prod_b;
    logic [DW-1:0]               div_t_reg, div_b_reg;
    logic [EDGE_BITS-1:0]        wm1_c_reg, h_c_reg;
    logic [RB-1:0]               rd;
    logic [SW-1:0]               sq_next, sq_reg;
    logic [RB-1:0]               radius_c_reg;
    logic signed [COORD_BITS:0]  x_c_reg, y0_c_reg;
    rec_flags_t                  flags_next, flags_reg;

    always_comb begin
        pre_ok_a_next = (eye_w >= EDGE_BITS'(MIN_EDGE)) &&
                        (eye_height >= EDGE_BITS'(MIN_EDGE)) && (column < eye_w);
        wm1_a_next    = eye_w - EDGE_BITS'(1);
        rdist         = wm1_a_next - column;
        edist_a_next  = (column < rdist) ? column : rdist;
        short_side    = (eye_w < eye_height) ? eye_w : eye_height;
        tl            = left_side ? top_outer_lid    : top_inner_lid;
        tr            = left_side ? top_inner_lid    : top_outer_lid;
        bl            = left_side ? bottom_outer_lid : bottom_inner_lid;
        br            = left_side ? bottom_inner_lid : bottom_outer_lid;
        p_tl_a_next   = PW'(tl) * PW'(rdist);
        p_tr_a_next   = PW'(tr) * PW'(column);
        p_bl_a_next   = PW'(bl) * PW'(rdist);
        p_br_a_next   = PW'(br) * PW'(column);
        rprod_a_next  = PW'(corner_fraction) * PW'(short_side);
        x_a_next      = {pos_x[COORD_BITS-1], pos_x}
                        - (COORD_BITS+1)'(eye_w[EDGE_BITS-1:1])
                        + (COORD_BITS+1)'(column);
        y0_a_next     = {pos_y[COORD_BITS-1], pos_y}
                        - (COORD_BITS+1)'(eye_height[EDGE_BITS-1:1]);
    end

    always_comb begin
        sum_t_b_next  = p_tl_a_reg + p_tr_a_reg;
        sum_b_b_next  = p_bl_a_reg + p_br_a_reg;
        r0            = rprod_a_reg[PW-1:FRAC_BITS];
        r1            = (r0 > (EDGE_BITS+1)'(half_w_a_reg)) ? half_w_a_reg : r0[RB-1:0];
        r2            = (r1 > half_h_a_reg) ? half_h_a_reg : r1;
        radius_b_next = (r2 == '0) ? RB'(1) : r2;
    end

    always_comb begin
        prod_t     = MW'(sum_t_b_reg) * MW'(h_b_reg);
        prod_b     = MW'(sum_b_b_reg) * MW'(h_b_reg);
        rd         = radius_b_reg - edist_b_reg[RB-1:0];
        sq_next    = SW'(radius_b_reg) * SW'(radius_b_reg) - SW'(rd) * SW'(rd);
        flags_next.pre_ok    = pre_ok_b_reg;
        flags_next.corner_on = edist_b_reg < EDGE_BITS'(radius_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pre_ok_a_reg <= pre_ok_a_next;
            wm1_a_reg    <= wm1_a_next;
            edist_a_reg  <= edist_a_next;
            half_w_a_reg <= eye_w[EDGE_BITS-1:1];
            half_h_a_reg <= eye_height[EDGE_BITS-1:1];
            h_a_reg      <= eye_height;
            p_tl_a_reg   <= p_tl_a_next;
            p_tr_a_reg   <= p_tr_a_next;
            p_bl_a_reg   <= p_bl_a_next;
            p_br_a_reg   <= p_br_a_next;
            rprod_a_reg  <= rprod_a_next;
            x_a_reg      <= x_a_next;
            y0_a_reg     <= y0_a_next;
        end
        if (stage_en[1]) begin
            sum_t_b_reg  <= sum_t_b_next;
            sum_b_b_reg  <= sum_b_b_next;
            radius_b_reg <= radius_b_next;
            pre_ok_b_reg <= pre_ok_a_reg;
            wm1_b_reg    <= wm1_a_reg;
            edist_b_reg  <= edist_a_reg;
            h_b_reg      <= h_a_reg;
            x_b_reg      <= x_a_reg;
            y0_b_reg     <= y0_a_reg;
        end
        if (stage_en[2]) begin
            div_t_reg    <= prod_t[MW-1:FRAC_BITS];
            div_b_reg    <= prod_b[MW-1:FRAC_BITS];
            wm1_c_reg    <= wm1_b_reg;
            h_c_reg      <= h_b_reg;
            sq_reg       <= sq_next;
            radius_c_reg <= radius_b_reg;
            x_c_reg      <= x_b_reg;
            y0_c_reg     <= y0_b_reg;
            flags_reg    <= flags_next;
        end
    end

    assign div_top  = div_t_reg;
    assign div_bot  = div_b_reg;
    assign divisor  = wm1_c_reg;
    assign root_arg = sq_reg;
    assign radius   = radius_c_reg;
    assign height   = h_c_reg;
    assign span_x   = x_c_reg;
    assign y_base   = y0_c_reg;
    assign flags    = flags_reg;

endmodule

@@ hw/rtl/rec_div.sv @@
module rec_div #(
    parameter int EDGE_BITS = 8
) (
    input  logic                              aclk,
    input  logic [rec_pkg::ITER_STAGES-1:0]   stage_en,
    input  logic [2*EDGE_BITS:0]              dividend,
    input  logic [EDGE_BITS-1:0]              divisor,
    output logic [EDGE_BITS:0]                quotient
);
    import rec_pkg::*;

    localparam int DW  = 2 * EDGE_BITS + 1;
    localparam int QW  = EDGE_BITS + 1;
    localparam int SPS = (QW + ITER_STAGES - 1) / ITER_STAGES;

    logic [DW-1:0]        rem_reg [0:ITER_STAGES-2];
    logic [EDGE_BITS-1:0] dv_reg  [0:ITER_STAGES-2];
    logic [QW-1:0]        q_reg   [0:ITER_STAGES-1];

    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_stage
        logic [DW-1:0]        rem_in, rem_next;
        logic [EDGE_BITS-1:0] dv_in;
        logic [QW-1:0]        q_in, q_next;

        if (s == 0) begin : g_first
            assign rem_in = dividend;
            assign dv_in  = divisor;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign dv_in  = dv_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        // restoring steps, quotient MSB first
        always_comb begin
            logic [DW-1:0] rem_v;
            logic [DW-1:0] trial;
            logic [QW-1:0] q_v;
            int            idx;
            rem_v = rem_in;
            q_v   = q_in;
            trial = '0;
            for (int k = 0; k < SPS; k++) begin
                idx = s * SPS + k;
                if (idx < QW) begin
                    trial = DW'(dv_in) << (QW - 1 - idx);
                    if (rem_v >= trial) begin
                        rem_v              = rem_v - trial;
                        q_v[QW - 1 - idx]  = 1'b1;
                    end
                end
            end
            rem_next = rem_v;
            q_next   = q_v;
        end

        if (s < ITER_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    rem_reg[s] <= rem_next;
                    dv_reg[s]  <= dv_in;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                q_reg[s] <= q_next;
            end
        end
    end

    assign quotient = q_reg[ITER_STAGES-1];

endmodule

@@ hw/rtl/rec_isqrt.sv @@
module rec_isqrt #(
    parameter int EDGE_BITS = 8
) (
    input  logic                              aclk,
    input  logic [rec_pkg::ITER_STAGES-1:0]   stage_en,
    input  logic [2*EDGE_BITS-3:0]            arg,
    output logic [EDGE_BITS-2:0]              root
);
    import rec_pkg::*;

    localparam int RB  = EDGE_BITS - 1;
    localparam int SW  = 2 * RB;
    localparam int SPS = (RB + ITER_STAGES - 1) / ITER_STAGES;

    logic [SW-1:0] v_reg   [0:ITER_STAGES-2];
    logic [SW-1:0] res_reg [0:ITER_STAGES-1];

    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_stage
        logic [SW-1:0] v_in, v_next;
        logic [SW-1:0] res_in, res_next;

        if (s == 0) begin : g_first
            assign v_in   = arg;
            assign res_in = '0;
        end else begin : g_rest
            assign v_in   = v_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        // digit-by-digit root, two argument bits per step
        always_comb begin
            logic [SW:0] v_v;
            logic [SW:0] res_v;
            logic [SW:0] bit_v;
            logic [SW:0] trial;
            int          idx;
            v_v   = {1'b0, v_in};
            res_v = {1'b0, res_in};
            bit_v = '0;
            trial = '0;
            for (int k = 0; k < SPS; k++) begin
                idx = s * SPS + k;
                if (idx < RB) begin
                    bit_v = (SW+1)'(1) << (SW - 2 - 2 * idx);
                    trial = res_v + bit_v;
                    if (v_v >= trial) begin
                        v_v   = v_v - trial;
                        res_v = (res_v >> 1) + bit_v;
                    end else begin
                        res_v = res_v >> 1;
                    end
                end
            end
            v_next   = v_v[SW-1:0];
            res_next = res_v[SW-1:0];
        end

        if (s < ITER_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    v_reg[s] <= v_next;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                res_reg[s] <= res_next;
            end
        end
    end

    assign root = res_reg[ITER_STAGES-1][RB-1:0];

endmodule

@@ hw/rtl/rounded_eye_column_span.sv @@
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: eye shape and column; s_tuser: left_side
// m_       out  m_tvalid/m_tready  m_tdata: span_x, span_top, span_length; m_tuser: span_valid
//
// Seven register stages from input transfer to output register: three front
// stages (swap, products, radius clamp, lid sums, scaling by height), three
// stages of the lid dividers and corner square root, one stage for the row
// math. Accepts one transfer per clock while the output is not stalled by m_tready.
// aresetn (synchronous) clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled; bubbles are squeezed out.
module rounded_eye_column_span #(
    parameter int FRAC_BITS  = 8,
    parameter int EDGE_BITS  = 8,
    parameter int COORD_BITS = 11
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pos_x, pos_y, eye_w, eye_height, corner_fraction, top_outer_lid,
    // top_inner_lid, bottom_outer_lid, bottom_inner_lid, column
    input  logic [((2*COORD_BITS+3*EDGE_BITS+5*FRAC_BITS+5+7)/8)*8-1:0] s_tdata,
    // left_side
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // span_x, span_top, span_length
    output logic [((2*COORD_BITS+2+EDGE_BITS+7)/8)*8-1:0] m_tdata,
    // span_valid
    output logic m_tuser
);
    import rec_pkg::*;

    localparam int NUM_STAGES = FRONT_STAGES + ITER_STAGES + 1;
    localparam int RB         = EDGE_BITS - 1;
    localparam int LW         = EDGE_BITS + 4;
    localparam int MDW        = ((2*COORD_BITS+2+EDGE_BITS+7)/8)*8;

    localparam int OFF_CY  = COORD_BITS;
    localparam int OFF_W   = 2 * COORD_BITS;
    localparam int OFF_H   = OFF_W + EDGE_BITS;
    localparam int OFF_CF  = OFF_H + EDGE_BITS;
    localparam int OFF_TO  = OFF_CF + FRAC_BITS + 1;
    localparam int OFF_TI  = OFF_TO + FRAC_BITS + 1;
    localparam int OFF_BO  = OFF_TI + FRAC_BITS + 1;
    localparam int OFF_BI  = OFF_BO + FRAC_BITS + 1;
    localparam int OFF_COL = OFF_BI + FRAC_BITS + 1;

    typedef struct packed {
        rec_flags_t                 flags;
        logic [RB-1:0]              radius;
        logic [EDGE_BITS-1:0]       height;
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y0;
    } side_t;

    logic [NUM_STAGES-1:0]       valid_reg, valid_next;
    logic [NUM_STAGES-1:0]       en;

    logic [2*EDGE_BITS:0]        div_top, div_bot;
    logic [EDGE_BITS-1:0]        divisor;
    logic [2*EDGE_BITS-3:0]      root_arg;
    logic [RB-1:0]               radius;
    logic [EDGE_BITS-1:0]        height;
    logic signed [COORD_BITS:0]  span_x, y_base;
    rec_flags_t                  flags;

    logic [EDGE_BITS:0]          q_top, q_bot;
    logic [RB-1:0]               root;

    side_t                       side_reg  [0:ITER_STAGES-1];
    side_t                       side_next [0:ITER_STAGES-1];
    side_t                       side_out;

    logic [RB-1:0]               corner;
    logic signed [LW-1:0]        len_full;
    logic                        span_ok_next, span_ok_reg;
    logic signed [COORD_BITS:0]  span_x_next, span_x_reg;
    logic signed [COORD_BITS:0]  span_top_next, span_top_reg;
    logic [EDGE_BITS-1:0]        span_len_next, span_len_reg;

    // stage advance: a stage loads when it is empty or the next one loads
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = {valid_reg[NUM_STAGES-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    rec_front #(
        .FRAC_BITS (FRAC_BITS),
        .EDGE_BITS (EDGE_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk            (aclk),
        .stage_en        (en[FRONT_STAGES-1:0]),
        .pos_x           (s_tdata[COORD_BITS-1:0]),
        .pos_y           (s_tdata[OFF_CY +: COORD_BITS]),
        .eye_w           (s_tdata[OFF_W +: EDGE_BITS]),
        .eye_height      (s_tdata[OFF_H +: EDGE_BITS]),
        .left_side       (s_tuser),
        .corner_fraction (s_tdata[OFF_CF +: FRAC_BITS+1]),
        .top_outer_lid   (s_tdata[OFF_TO +: FRAC_BITS+1]),
        .top_inner_lid   (s_tdata[OFF_TI +: FRAC_BITS+1]),
        .bottom_outer_lid(s_tdata[OFF_BO +: FRAC_BITS+1]),
        .bottom_inner_lid(s_tdata[OFF_BI +: FRAC_BITS+1]),
        .column          (s_tdata[OFF_COL +: EDGE_BITS]),
        .div_top         (div_top),
        .div_bot         (div_bot),
        .divisor         (divisor),
        .root_arg        (root_arg),
        .radius          (radius),
        .height          (height),
        .span_x          (span_x),
        .y_base          (y_base),
        .flags           (flags)
    );

    rec_div #(.EDGE_BITS(EDGE_BITS)) u_div_top (
        .aclk    (aclk),
        .stage_en(en[FRONT_STAGES +: ITER_STAGES]),
        .dividend(div_top),
        .divisor (divisor),
        .quotient(q_top)
    );

    rec_div #(.EDGE_BITS(EDGE_BITS)) u_div_bot (
        .aclk    (aclk),
        .stage_en(en[FRONT_STAGES +: ITER_STAGES]),
        .dividend(div_bot),
        .divisor (divisor),
        .quotient(q_bot)
    );

    rec_isqrt #(.EDGE_BITS(EDGE_BITS)) u_isqrt (
        .aclk    (aclk),
        .stage_en(en[FRONT_STAGES +: ITER_STAGES]),
        .arg     (root_arg),
        .root    (root)
    );

    // sideband follows the divider stages
    always_comb begin
        side_next[0].flags  = flags;
        side_next[0].radius = radius;
        side_next[0].height = height;
        side_next[0].x      = span_x;
        side_next[0].y0     = y_base;
        for (int i = 1; i < ITER_STAGES; i++) begin
            side_next[i] = side_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ITER_STAGES; i++) begin
            if (en[FRONT_STAGES+i]) begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign side_out = side_reg[ITER_STAGES-1];

    always_comb begin
        corner        = side_out.flags.corner_on ? (side_out.radius - root) : '0;
        len_full      = LW'(side_out.height) - LW'(q_top) - LW'(q_bot) - LW'({corner, 1'b0});
        span_ok_next  = side_out.flags.pre_ok && (len_full > 0);
        span_x_next   = span_ok_next ? side_out.x : '0;
        span_top_next = span_ok_next
                        ? side_out.y0 + (COORD_BITS+1)'(q_top) + (COORD_BITS+1)'(corner)
                        : '0;
        span_len_next = span_ok_next ? len_full[EDGE_BITS-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (en[NUM_STAGES-1]) begin
            span_ok_reg  <= span_ok_next;
            span_x_reg   <= span_x_next;
            span_top_reg <= span_top_next;
            span_len_reg <= span_len_next;
        end
    end

    assign m_tdata = MDW'({span_len_reg, span_top_reg, span_x_reg});
    assign m_tuser = span_ok_reg;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_transfer_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transfer not captured in first stage");

    a_span_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (span_len_reg != '0))
        else $error("valid span with zero length");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (span_len_reg == '0 && span_top_reg == '0 && span_x_reg == '0))
        else $error("invalid span carries nonzero fields");
`endif

endmodule
